/* hdl/rch_pkg.sv */
// ----------------------------------------------------------------------------
// RGB color histogram package
// Shared sizes, operation codes and beat payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rch_pkg;

  localparam int CHAN_BINS        = 8;
  localparam int CHAN_BITS        = $clog2(CHAN_BINS);
  localparam int HIST_BINS        = CHAN_BINS * CHAN_BINS * CHAN_BINS;
  localparam int BIN_AW           = $clog2(HIST_BINS);
  localparam int SEL_WIDTH        = 9;
  localparam int COUNT_WIDTH      = 23;
  localparam int FRAC_WIDTH       = 17;
  localparam int FRAC_SHIFT       = 16;
  localparam int DIV_STEPS        = FRAC_SHIFT + 1;
  localparam int STEP_BITS        = $clog2(DIV_STEPS);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [SEL_WIDTH-1:0] bin_select;
  } req_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] bin_count;
    logic [FRAC_WIDTH-1:0]  fraction;
    logic [COUNT_WIDTH-1:0] pixel_total;
  } rsp_t;

  function automatic logic [CHAN_BITS-1:0] chan_bin(input logic [7:0] value);
    logic [15:0] prod;
    prod = 16'(value) * 16'(CHAN_BINS);
    return prod[8 +: CHAN_BITS];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] value);
    return (value == COUNT_MAX) ? value : value + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

/* hdl/rch_if.sv */
// ----------------------------------------------------------------------------
// RGB color histogram channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rch_req_if;
  logic          valid;
  logic          ready;
  rch_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rch_rsp_if;
  logic          valid;
  logic          ready;
  rch_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/rgb_color_histogram.sv */
// ----------------------------------------------------------------------------
// RGB color histogram
// 8x8x8 color histogram with saturating bin counts, a pixel total and a
// Q16 share of one bin computed by a bit-serial divider.
// ----------------------------------------------------------------------------
// Add beats are taken one per cycle while no clear pass or read is busy:
// the bin count is read from the 512-entry memory, incremented in the next
// cycle and written back, with the last write forwarded so that adds to the
// same bin may follow back to back.
// A read beat passes through the memory read, the load of the divider, 17
// steps of the restoring divider that forms count * 65536 / total, and the
// load of the response register; a previous response still waiting to be
// taken delays that load, and no new beat is taken until the divider is free.
// A clear beat, and also reset, starts a pass that writes zero to every bin,
// one bin a cycle, during which no request beat is taken.
`default_nettype none

module rgb_color_histogram (
  input  wire          clk,
  input  wire          rst,
  rch_req_if.sink      req,
  rch_rsp_if.source    rsp
);
  import rch_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_HOLD = 3'b100
  } dv_state_t;

  logic [COUNT_WIDTH-1:0] mem [HIST_BINS];
  logic [COUNT_WIDTH-1:0] rd_data;

  logic                   mem_we;
  logic [BIN_AW-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [BIN_AW-1:0]      rd_addr;
  logic [BIN_AW-1:0]      pix_addr;

  logic                   clr_active;
  logic [BIN_AW-1:0]      clr_addr;
  logic [COUNT_WIDTH-1:0] total;

  logic                   s1_valid;
  op_t                    s1_op;
  logic [BIN_AW-1:0]      s1_addr;

  logic                   fwd_valid;
  logic [BIN_AW-1:0]      fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic                   add_we;

  dv_state_t              dv_state;
  logic [STEP_BITS-1:0]   dv_step;
  logic [COUNT_WIDTH-1:0] dv_rem;
  logic [COUNT_WIDTH-1:0] dv_den;
  logic [FRAC_WIDTH-1:0]  dv_quo;
  logic [COUNT_WIDTH-1:0] dv_count;
  logic                   dv_zero;
  logic [COUNT_WIDTH:0]   dv_partial;
  logic                   dv_ge;
  logic [COUNT_WIDTH:0]   dv_diff;
  logic [FRAC_WIDTH-1:0]  dv_quo_next;

  logic                   accept;
  logic                   rsp_free;
  logic                   rsp_load;

  assign req.ready = !clr_active && (dv_state == DV_IDLE)
                     && !(s1_valid && (s1_op == OP_READ));
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = (dv_state == DV_HOLD) && rsp_free;

  assign pix_addr = BIN_AW'({chan_bin(req.data.red), chan_bin(req.data.green),
                             chan_bin(req.data.blue)});
  assign rd_addr  = (op_t'(req.data.op) == OP_ADD) ? pix_addr
                                                   : req.data.bin_select[BIN_AW-1:0];

  assign cur_count = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign inc_count = sat_inc(cur_count);
  assign add_we    = s1_valid && (s1_op == OP_ADD);

  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = add_we;
      mem_waddr = s1_addr;
      mem_wdata = inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      total      <= '0;
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= add_we && !clr_active;
      if (clr_active) begin
        if (clr_addr == BIN_AW'(HIST_BINS - 1)) begin
          clr_active <= 1'b0;
        end
        clr_addr <= clr_addr + BIN_AW'(1);
      end
      if (accept) begin
        case (op_t'(req.data.op))
          OP_ADD: begin
            total <= sat_inc(total);
          end
          OP_CLEAR: begin
            total      <= '0;
            clr_active <= 1'b1;
            clr_addr   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op_t'(req.data.op);
      s1_addr <= rd_addr;
    end
    fwd_addr <= s1_addr;
    fwd_data <= inc_count;
  end

  assign dv_partial  = (dv_step == '0) ? {1'b0, dv_rem} : {dv_rem, 1'b0};
  assign dv_ge       = dv_partial >= {1'b0, dv_den};
  assign dv_diff     = dv_partial - {1'b0, dv_den};
  assign dv_quo_next = {dv_quo[FRAC_WIDTH-2:0], dv_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state  <= DV_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (dv_state)
        DV_IDLE: begin
          if (s1_valid && (s1_op == OP_READ)) begin
            dv_state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (dv_step == STEP_BITS'(DIV_STEPS - 1)) begin
            dv_state <= DV_HOLD;
          end
        end
        DV_HOLD: begin
          if (rsp_free) begin
            dv_state <= DV_IDLE;
          end
        end
        default: begin
          dv_state <= DV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dv_state)
      DV_IDLE: begin
        dv_rem   <= cur_count;
        dv_den   <= total;
        dv_count <= cur_count;
        dv_zero  <= (total == '0);
        dv_step  <= '0;
        dv_quo   <= '0;
      end
      DV_RUN: begin
        dv_rem  <= dv_ge ? dv_diff[COUNT_WIDTH-1:0] : dv_partial[COUNT_WIDTH-1:0];
        dv_quo  <= dv_quo_next;
        dv_step <= dv_step + STEP_BITS'(1);
      end
      DV_HOLD: begin
        if (rsp_free) begin
          rsp.data.bin_count   <= dv_count;
          rsp.data.fraction    <= dv_zero ? '0 : dv_quo;
          rsp.data.pixel_total <= dv_den;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// RGB color histogram testbench
// Drives pixel, read, clear and unused-op beats into the histogram and checks
// every read response against a cycle-free model of the bins and the total or
// the reply pinned in its row. A directed table comes first, then random traffic
// in four handshake phases: no idling, idle sender, stalling receiver, and both together.
// ----------------------------------------------------------------------------

module testbench;

  import rch_pkg::*;

  typedef struct {
    req_t beat;
    bit   pinned;
    rsp_t reply;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 412;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rch_req_if req_ch();
  rch_rsp_if rsp_ch();

  rgb_color_histogram DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [COUNT_WIDTH-1:0] bin_tally [HIST_BINS] = '{default: '0};
  logic [COUNT_WIDTH-1:0] pixel_tally = '0;
  rsp_t                   pending_reads [$];
  stim_row_t              directed [$];

  logic pin_flag  = 1'b0;
  rsp_t pin_reply = '0;

  int errors         = 0;
  int adds_seen      = 0;
  int reads_checked  = 0;
  int clears_seen    = 0;
  int ignored_seen   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #10 clk = ~clk;

  function automatic rsp_t histogram_read(logic [SEL_WIDTH-1:0] sel);
    rsp_t        r;
    logic [63:0] q;
    r.bin_count   = bin_tally[sel];
    r.pixel_total = pixel_tally;
    q = '0;
    if (pixel_tally != '0) begin
      q = ({41'd0, bin_tally[sel]} << FRAC_SHIFT) / {41'd0, pixel_tally};
      if (q > 64'd65536) q = 64'd65536;
    end
    r.fraction = q[FRAC_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [BIN_AW-1:0] pixel_bin(req_t b);
    return {b.red[7 -: CHAN_BITS], b.green[7 -: CHAN_BITS], b.blue[7 -: CHAN_BITS]};
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t              want;
    logic [BIN_AW-1:0] idx;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_reads.size() == 0) begin
          $error("response beat with no read outstanding");
          errors++;
        end else begin
          want = pending_reads.pop_front();
          reads_checked++;
          if (rsp_ch.data.bin_count !== want.bin_count) begin
            $error("bin_count expected %0d, got %0d", want.bin_count, rsp_ch.data.bin_count);
            errors++;
          end
          if (rsp_ch.data.fraction !== want.fraction) begin
            $error("fraction expected %0d, got %0d", want.fraction, rsp_ch.data.fraction);
            errors++;
          end
          if (rsp_ch.data.pixel_total !== want.pixel_total) begin
            $error("pixel_total expected %0d, got %0d", want.pixel_total,
                   rsp_ch.data.pixel_total);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        case (op_t'(req_ch.data.op))
          OP_ADD: begin
            idx = pixel_bin(req_ch.data);
            if (bin_tally[idx] != COUNT_MAX) bin_tally[idx] = bin_tally[idx] + 1'b1;
            if (pixel_tally != COUNT_MAX) pixel_tally = pixel_tally + 1'b1;
            adds_seen++;
          end
          OP_READ: begin
            pending_reads.insert(pending_reads.size(),
                                 pin_flag ? pin_reply
                                          : histogram_read(req_ch.data.bin_select));
          end
          OP_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            pixel_tally = '0;
            clears_seen++;
          end
          default: ignored_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drive_beat(req_t beat, bit pinned, rsp_t reply);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= beat;
    pin_flag     <= pinned;
    pin_reply    <= reply;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic add_row(op_t op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                         logic [SEL_WIDTH-1:0] sel, bit pinned,
                         int cnt, int frac, int tot);
    stim_row_t row;
    row.beat.op            = op;
    row.beat.blue          = b;
    row.beat.green         = g;
    row.beat.red           = r;
    row.beat.bin_select    = sel;
    row.pinned             = pinned;
    row.reply.bin_count    = COUNT_WIDTH'(cnt);
    row.reply.fraction     = FRAC_WIDTH'(frac);
    row.reply.pixel_total  = COUNT_WIDTH'(tot);
    directed.insert(directed.size(), row);
  endtask

  initial begin : stimulus
    int                  send_pct [4];
    int                  recv_pct [4];
    req_t                beat;
    rsp_t                none;
    logic [BIN_AW-1:0]   hot_bin;
    logic [BIN_AW-1:0]   last_bin;
    int                  pick;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    send_pct = '{0, 63, 0, 18};
    recv_pct = '{0, 0, 63, 18};
    none     = '0;
    hot_bin  = '0;
    last_bin = '0;

    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd0,   1, 0, 0, 0);
    add_row(OP_READ,  8'hff, 8'hff, 8'hff, 9'd511, 1, 0, 0, 0);
    add_row(OP_ADD,   8'h00, 8'h00, 8'h00, 9'd511, 0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd0,   1, 1, 65536, 1);
    add_row(OP_ADD,   8'hff, 8'hff, 8'hff, 9'd0,   0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd511, 1, 1, 32768, 2);
    add_row(OP_ADD,   8'hff, 8'h00, 8'h00, 9'd0,   0, 0, 0, 0);
    add_row(OP_ADD,   8'h00, 8'hff, 8'h00, 9'd0,   0, 0, 0, 0);
    add_row(OP_ADD,   8'h00, 8'h00, 8'hff, 9'd0,   0, 0, 0, 0);
    add_row(OP_ADD,   8'h20, 8'h1f, 8'he0, 9'd0,   0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd7,   0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd56,  0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd448, 0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd449, 0, 0, 0, 0);
    add_row(OP_NONE,  8'hff, 8'h5a, 8'ha5, 9'd511, 0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd0,   0, 0, 0, 0);
    add_row(OP_CLEAR, 8'hff, 8'hff, 8'hff, 9'd511, 0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd511, 1, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd0,   1, 0, 0, 0);
    add_row(OP_ADD,   8'h1f, 8'h1f, 8'h1f, 9'd0,   0, 0, 0, 0);
    add_row(OP_ADD,   8'h20, 8'h20, 8'h20, 9'd0,   0, 0, 0, 0);
    add_row(OP_ADD,   8'h1f, 8'h1f, 8'h1f, 9'd0,   0, 0, 0, 0);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd0,   1, 2, 43690, 3);
    add_row(OP_READ,  8'h00, 8'h00, 8'h00, 9'd73,  0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) drive_beat(directed[i].beat, directed[i].pinned, directed[i].reply);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) < 5) hot_bin = BIN_AW'($urandom_range(HIST_BINS - 1));
        beat.blue       = 8'($urandom_range(255));
        beat.green      = 8'($urandom_range(255));
        beat.red        = 8'($urandom_range(255));
        beat.bin_select = SEL_WIDTH'($urandom_range(HIST_BINS - 1));
        pick = $urandom_range(99);
        if (pick < 60) begin
          beat.op = OP_ADD;
          if ($urandom_range(1) == 1) begin
            beat.red[7 -: CHAN_BITS]   = hot_bin[8:6];
            beat.green[7 -: CHAN_BITS] = hot_bin[5:3];
            beat.blue[7 -: CHAN_BITS]  = hot_bin[2:0];
          end
          last_bin = pixel_bin(beat);
        end else if (pick < 93) begin
          beat.op = OP_READ;
          pick = $urandom_range(99);
          if (pick < 40) beat.bin_select = hot_bin;
          else if (pick < 60) beat.bin_select = last_bin;
        end else if (pick < 97) begin
          beat.op = OP_NONE;
        end else begin
          beat.op = OP_CLEAR;
        end
        drive_beat(beat, 1'b0, none);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (pending_reads.size() != 0) begin
      $error("%0d read responses never arrived", pending_reads.size());
      errors++;
    end

    $display("Covered %0d pixel adds, %0d checked reads, %0d clears and %0d unused-op beats",
             adds_seen, reads_checked, clears_seen, ignored_seen);
    $display("over four handshake phases with idle senders and stalling receivers.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Run timed out with %0d read responses outstanding.", pending_reads.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
